>>> rtl/core/eois_pkg.sv
package eois_pkg;

  localparam int CAPACITY_DEFAULT = 1024;

  localparam int VALUE_W  = 31;
  localparam int STATUS_W = 2;
  localparam int KEY_W    = VALUE_W + 1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  popped_value;
    logic [STATUS_W-1:0] status;
    logic                last_value;
  } out_item_t;

  // Even values sort first in ascending order, then odd values in descending
  // order. Inverting an odd value reverses its order within the odd half.
  function automatic logic [KEY_W-1:0] order_key(input logic [VALUE_W-1:0] v);
    logic [KEY_W-1:0] k;
    if (v[0]) begin
      k = {1'b1, ~v};
    end else begin
      k = {1'b0, v};
    end
    return k;
  endfunction

endpackage

>>> rtl/core/eois_mem.sv
module eois_mem #(
  parameter int CAPACITY = eois_pkg::CAPACITY_DEFAULT,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [eois_pkg::VALUE_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [eois_pkg::VALUE_W-1:0] rd_data
);

  logic [eois_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic [eois_pkg::VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/eois_ctrl.sv
module eois_ctrl #(
  parameter int CAPACITY = eois_pkg::CAPACITY_DEFAULT,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  eois_pkg::in_item_t           in_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output eois_pkg::out_item_t          res_data,
  output logic                         mem_wr_en,
  output logic [AW-1:0]                mem_wr_addr,
  output logic [eois_pkg::VALUE_W-1:0] mem_wr_data,
  output logic [AW-1:0]                mem_rd_addr,
  input  logic [eois_pkg::VALUE_W-1:0] mem_rd_data
);

  localparam int XW = AW + 2;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_UP_RD   = 9'b000000010,
    S_UP_CMP  = 9'b000000100,
    S_POP_TOP = 9'b000001000,
    S_POP_LAST= 9'b000010000,
    S_DN_RD   = 9'b000100000,
    S_DN_L    = 9'b001000000,
    S_DN_R    = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;
  logic [AW-1:0]                cidx_r, cidx_nxt;
  logic [eois_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [eois_pkg::VALUE_W-1:0] cand_r, cand_nxt;
  eois_pkg::out_item_t          res_r, res_nxt;

  logic [AW-1:0]                parent;
  logic [XW-1:0]                left_x;
  logic [XW-1:0]                right_x;
  logic [XW-1:0]                count_x;
  logic                         take_right;
  logic [eois_pkg::VALUE_W-1:0] child_val;
  logic [AW-1:0]                child_idx;
  logic                         in_fire;

  assign parent  = AW'((idx_r - AW'(1)) >> 1);
  assign left_x  = XW'({idx_r, 1'b1});
  assign right_x = XW'(cidx_r) + XW'(1);
  assign count_x = XW'(count_r);

  // The right child wins only when it exists and holds a smaller key.
  assign take_right = (right_x < count_x) &&
                      (eois_pkg::order_key(mem_rd_data) < eois_pkg::order_key(cand_r));
  assign child_val  = take_right ? mem_rd_data : cand_r;
  assign child_idx  = take_right ? right_x[AW-1:0] : cidx_r;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign res_valid = (state_r == S_DONE);
  assign res_data  = res_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cidx_nxt    = cidx_r;
    val_nxt     = val_r;
    cand_nxt    = cand_r;
    res_nxt     = res_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r;
    mem_wr_data = val_r;
    mem_rd_addr = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt.popped_value = '0;
          res_nxt.status       = eois_pkg::STATUS_OK;
          res_nxt.last_value   = 1'b0;
          if (in_data.operation == eois_pkg::OP_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              res_nxt.status = eois_pkg::STATUS_FULL;
              state_nxt      = S_DONE;
            end else begin
              val_nxt   = in_data.value;
              idx_nxt   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              state_nxt = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt.status = eois_pkg::STATUS_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              // The root is read on this edge.
              count_nxt = count_r - CW'(1);
              state_nxt = S_POP_TOP;
            end
          end
        end
      end

      S_UP_RD: begin
        if (idx_r == '0) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = idx_r;
          mem_wr_data = val_r;
          state_nxt   = S_DONE;
        end else begin
          mem_rd_addr = parent;
          state_nxt   = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r;
        if (eois_pkg::order_key(mem_rd_data) > eois_pkg::order_key(val_r)) begin
          mem_wr_data = mem_rd_data;
          idx_nxt     = parent;
          state_nxt   = S_UP_RD;
        end else begin
          mem_wr_data = val_r;
          state_nxt   = S_DONE;
        end
      end

      S_POP_TOP: begin
        res_nxt.popped_value = mem_rd_data;
        res_nxt.last_value   = (count_r == '0);
        mem_rd_addr          = count_r[AW-1:0];
        state_nxt            = (count_r == '0) ? S_DONE : S_POP_LAST;
      end

      S_POP_LAST: begin
        val_nxt   = mem_rd_data;
        idx_nxt   = '0;
        state_nxt = S_DN_RD;
      end

      S_DN_RD: begin
        if (left_x >= count_x) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = idx_r;
          mem_wr_data = val_r;
          state_nxt   = S_DONE;
        end else begin
          mem_rd_addr = left_x[AW-1:0];
          cidx_nxt    = left_x[AW-1:0];
          state_nxt   = S_DN_L;
        end
      end

      S_DN_L: begin
        cand_nxt    = mem_rd_data;
        mem_rd_addr = right_x[AW-1:0];
        state_nxt   = S_DN_R;
      end

      S_DN_R: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r;
        if (eois_pkg::order_key(child_val) < eois_pkg::order_key(val_r)) begin
          mem_wr_data = child_val;
          idx_nxt     = child_idx;
          state_nxt   = S_DN_RD;
        end else begin
          mem_wr_data = val_r;
          state_nxt   = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r  <= idx_nxt;
    cidx_r <= cidx_nxt;
    val_r  <= val_nxt;
    cand_r <= cand_nxt;
    res_r  <= res_nxt;
  end

endmodule

>>> rtl/core/even_odd_insertion_sorter_top.sv
// Values are kept as a binary min-heap on the sort key in one memory with a registered read.
// An insert sifts its value up from its new slot, and a pop moves the last value to the root
// and sifts it down; full and empty cases, and a pop that empties the store, go straight to the
// result. The next input is taken only after the result has passed to the output register,
// which sets out_valid in the same cycle that in_ready rises again.
// Reset (rst_n, synchronous) empties the store; memory contents are not cleared.
module even_odd_insertion_sorter_top #(
  parameter int CAPACITY = eois_pkg::CAPACITY_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  eois_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output eois_pkg::out_item_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                         res_valid;
  logic                         res_ready;
  eois_pkg::out_item_t          res_data;
  logic                         mem_wr_en;
  logic [AW-1:0]                mem_wr_addr;
  logic [eois_pkg::VALUE_W-1:0] mem_wr_data;
  logic [AW-1:0]                mem_rd_addr;
  logic [eois_pkg::VALUE_W-1:0] mem_rd_data;

  logic                         out_valid_r, out_valid_nxt;
  eois_pkg::out_item_t          out_data_r;

  eois_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  eois_mem #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // The output register takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
